### hw/rtl/rs_pkg.sv
`default_nettype none

package rs_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ITEM_COUNT_W = 5;

  localparam logic [1:0] REQ_PUSH    = 2'd0;
  localparam logic [1:0] REQ_POP     = 2'd1;
  localparam logic [1:0] REQ_REVERSE = 2'd2;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [WORD_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] top_value;
    logic                     is_empty;
    logic [ITEM_COUNT_W-1:0]  item_count;
    logic                     overflow;
  } rsp_t;

  // Result info carried alongside the memory read.
  typedef struct packed {
    logic                     valid;
    logic                     bypass;
    logic                     is_empty;
    logic [ITEM_COUNT_W-1:0]  item_count;
    logic                     overflow;
    logic signed [WORD_W-1:0] push_value;
  } stage_t;

endpackage

`default_nettype wire

### hw/rtl/rs_mem.sv
`default_nettype none

module rs_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic                          we,
  input  wire logic [ADDR_W-1:0]             addr,
  input  wire logic [rs_pkg::WORD_W-1:0]     wdata,
  output logic      [rs_pkg::WORD_W-1:0]     rdata
);

  logic [rs_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rs_ctrl.sv
`default_nettype none

module rs_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned SLOT_W = 4,
  parameter int unsigned CNT_W = 5
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire rs_pkg::req_t              req,
  output logic                           mem_en,
  output logic                           mem_we,
  output logic [SLOT_W-1:0]              mem_addr,
  output logic [rs_pkg::WORD_W-1:0]      mem_wdata,
  output rs_pkg::stage_t                 stage
);

  localparam logic [SLOT_W:0] DEPTH_X = (SLOT_W+1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [CNT_W-1:0]  count, count_next;
  logic [SLOT_W-1:0] base_slot, base_slot_next;
  logic              grow_down, grow_down_next;

  logic [CNT_W-1:0]  pos_c;
  logic [SLOT_W:0]   pos_x;
  logic [SLOT_W:0]   base_x;
  logic [SLOT_W:0]   up_sum;
  logic [SLOT_W:0]   dn_diff;
  logic [SLOT_W-1:0] slot;
  logic              full;
  logic              nonempty;
  logic              push_ok;
  logic              ovf;

  assign full     = (count == DEPTH_C);
  assign nonempty = (count != '0);
  assign push_ok  = (req.req_type == rs_pkg::REQ_PUSH) && !full;
  assign ovf      = (req.req_type == rs_pkg::REQ_PUSH) && full;

  always_comb begin
    case (req.req_type)
      rs_pkg::REQ_PUSH: pos_c = full ? count - CNT_W'(1) : count;
      rs_pkg::REQ_POP:  pos_c = count - CNT_W'(2);
      default:          pos_c = count - CNT_W'(1);
    endcase
  end

  // Slot of position pos from the bottom, wrapping modulo DEPTH.
  assign pos_x   = {1'b0, pos_c[SLOT_W-1:0]};
  assign base_x  = {1'b0, base_slot};
  assign up_sum  = base_x + pos_x;
  assign dn_diff = (base_x >= pos_x) ? base_x - pos_x : base_x + DEPTH_X - pos_x;

  always_comb begin
    if (grow_down) begin
      slot = dn_diff[SLOT_W-1:0];
    end else if (up_sum >= DEPTH_X) begin
      slot = SLOT_W'(up_sum - DEPTH_X);
    end else begin
      slot = up_sum[SLOT_W-1:0];
    end
  end

  always_comb begin
    count_next     = count;
    base_slot_next = base_slot;
    grow_down_next = grow_down;
    mem_addr       = slot;
    case (req.req_type)
      rs_pkg::REQ_PUSH: begin
        if (push_ok) begin
          count_next = count + CNT_W'(1);
        end
      end
      rs_pkg::REQ_POP: begin
        if (nonempty) begin
          count_next = count - CNT_W'(1);
        end
      end
      rs_pkg::REQ_REVERSE: begin
        if (nonempty) begin
          base_slot_next = slot;
          grow_down_next = !grow_down;
          mem_addr       = base_slot;
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_en    = accept;
  assign mem_we    = accept && push_ok;
  assign mem_wdata = req.push_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      base_slot   <= '0;
      grow_down   <= 1'b0;
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= accept;
      if (accept) begin
        count     <= count_next;
        base_slot <= base_slot_next;
        grow_down <= grow_down_next;
      end
    end
    if (accept) begin
      stage.bypass     <= push_ok;
      stage.is_empty   <= (count_next == '0);
      stage.item_count <= rs_pkg::ITEM_COUNT_W'(count_next);
      stage.overflow   <= ovf;
      stage.push_value <= req.push_value;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("stack count above depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    accept && ovf |=> count == DEPTH_C && stage.overflow)
    else $error("overflow without full stack");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == rs_pkg::REQ_POP && nonempty
      |=> count == $past(count) - CNT_W'(1))
    else $error("pop did not decrement count");

  a_rev_keep: assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == rs_pkg::REQ_REVERSE |=> $stable(count))
    else $error("reverse changed count");

endmodule

`default_nettype wire

### hw/rtl/reversible_stack_core.sv
`default_nettype none

// Result path: the stage register and the store read are loaded at the edge that
// takes start, and done and rsp are then registered from them.
// Throughput: one item per cycle whenever busy is low; the pointer update and the
// single-port store read of the new top both finish at the accepting edge.
// Reset (rst, synchronous): stack empties, grows upward, busy high during reset.
// Results cannot be held off by the receiver; each is shown for one cycle.
module reversible_stack_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire rs_pkg::req_t  req,
  output logic               done,
  output rs_pkg::rsp_t       rsp
);

  localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  logic                          accept;
  logic                          mem_en;
  logic                          mem_we;
  logic [SLOT_W-1:0]             mem_addr;
  logic [rs_pkg::WORD_W-1:0]     mem_wdata;
  logic [rs_pkg::WORD_W-1:0]     mem_rdata;
  rs_pkg::stage_t                stage;
  rs_pkg::rsp_t                  rsp_next;

  assign busy   = rst;
  assign accept = start && !busy;

  rs_ctrl #(
    .DEPTH  (DEPTH),
    .SLOT_W (SLOT_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .stage     (stage)
  );

  rs_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (SLOT_W)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    rsp_next.is_empty   = stage.is_empty;
    rsp_next.item_count = stage.item_count;
    rsp_next.overflow   = stage.overflow;
    if (stage.is_empty) begin
      rsp_next.top_value = rs_pkg::EMPTY_WORD;
    end else if (stage.bypass) begin
      rsp_next.top_value = stage.push_value;
    end else begin
      rsp_next.top_value = mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage.valid) begin
      rsp <= rsp_next;
    end
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    stage.valid |=> done)
    else $error("result lost");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(stage.valid))
    else $error("spurious result");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    done && rsp.is_empty |-> rsp.top_value == rs_pkg::EMPTY_WORD)
    else $error("empty stack shows a top word");

endmodule

`default_nettype wire
